FILE: src/glu_pkg.sv
// ----------------------------------------------------------------------------
// glu_pkg
// Shared types, constants and helper functions of the tracking loop update.
// ----------------------------------------------------------------------------
package glu_pkg;

    localparam int FreqFracBits  = 16;
    localparam int ErrFracBits   = 30;
    localparam int GainFracBits  = 24;
    localparam int ProdShift     = GainFracBits + ErrFracBits - FreqFracBits;
    localparam int CordicSteps   = 32;
    localparam int PrescaleShift = 20;
    localparam int CordicW       = 56;
    localparam int AngleW        = 34;
    localparam int TermW         = 28;
    localparam int AccW          = 50;

    localparam logic [47:0] CodeRateReset = 48'd67043510990;
    localparam logic signed [29:0] Quarter = 30'sd268435456;

    localparam logic [2:0] REG_CARRIER_PROP  = 3'd0;
    localparam logic [2:0] REG_CARRIER_INT   = 3'd1;
    localparam logic [2:0] REG_CODE_PROP     = 3'd2;
    localparam logic [2:0] REG_CODE_INT      = 3'd3;
    localparam logic [2:0] REG_CARRIER_BASIS = 3'd4;
    localparam logic [2:0] REG_CODE_BASIS    = 3'd5;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQ_EI, ST_SQ_EQ, ST_SQ_LI, ST_SQ_LQ, ST_SUM_L,
        ST_ROOT_E, ST_ROOT_L, ST_DIV, ST_PHASE,
        ST_F0, ST_F1, ST_F2, ST_F3, ST_F4, ST_CLAMP, ST_OUT
    } glu_state_t;

    typedef enum logic {
        ROOT_SQRT,
        ROOT_DIV
    } root_mode_t;

    typedef struct packed {
        logic       start;
        root_mode_t mode;
    } root_ctl_t;

    function automatic logic [29:0] angle_entry(input logic [4:0] k);
        logic [29:0] a;
        case (k)
            5'd0:  a = 30'd536870912;
            5'd1:  a = 30'd316933406;
            5'd2:  a = 30'd167458907;
            5'd3:  a = 30'd85004756;
            5'd4:  a = 30'd42667331;
            5'd5:  a = 30'd21354465;
            5'd6:  a = 30'd10679838;
            5'd7:  a = 30'd5340245;
            5'd8:  a = 30'd2670163;
            5'd9:  a = 30'd1335087;
            5'd10: a = 30'd667544;
            5'd11: a = 30'd333772;
            5'd12: a = 30'd166886;
            5'd13: a = 30'd83443;
            5'd14: a = 30'd41722;
            5'd15: a = 30'd20861;
            5'd16: a = 30'd10430;
            5'd17: a = 30'd5215;
            5'd18: a = 30'd2608;
            5'd19: a = 30'd1304;
            5'd20: a = 30'd652;
            5'd21: a = 30'd326;
            5'd22: a = 30'd163;
            5'd23: a = 30'd81;
            5'd24: a = 30'd41;
            5'd25: a = 30'd20;
            5'd26: a = 30'd10;
            5'd27: a = 30'd5;
            5'd28: a = 30'd3;
            5'd29: a = 30'd1;
            5'd30: a = 30'd1;
            default: a = 30'd0;
        endcase
        return a;
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic signed [TermW-1:0] round_term(input logic [63:0] p,
                                                           input logic neg);
        logic [64:0] s;
        logic [TermW-1:0] r;
        s = {1'b0, p} + (65'd1 << (ProdShift - 1));
        r = TermW'(s >> ProdShift);
        return neg ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [47:0] clamp48(input logic signed [AccW-1:0] v);
        logic signed [AccW-1:0] hi;
        logic signed [AccW-1:0] lo;
        hi = AccW'(48'sh7FFF_FFFF_FFFF);
        lo = -hi - AccW'(1);
        if (v > hi)
            return 48'sh7FFF_FFFF_FFFF;
        else if (v < lo)
            return 48'sh8000_0000_0000;
        else
            return v[47:0];
    endfunction

    function automatic logic [47:0] clamp_u48(input logic signed [AccW-1:0] v);
        if (v < 0)
            return 48'd0;
        else if (v > AccW'(48'hFFFF_FFFF_FFFF))
            return 48'hFFFF_FFFF_FFFF;
        else
            return v[47:0];
    endfunction

endpackage

FILE: src/gnss_pll_dll_loop_update.sv
// ----------------------------------------------------------------------------
// gnss_pll_dll_loop_update
// Costas PLL and early-minus-late DLL loop update, one code period per item.
// ----------------------------------------------------------------------------
// Each input transaction on the s_ group carries the six correlator sums of one
// code period. The block returns one output transaction on the m_ group with
// the phase error, the delay error, both filtered NCO commands and the carrier
// and code frequencies. The loop gains and frequency bases are written through
// the APB port; the user must write them only while the block is idle, and the
// block itself does not enforce it. Reads return the register values. The
// division is skipped when both envelopes are zero. The time of an item is set
// by the digit-serial root unit, which runs two 32-step square roots and a
// 31-step division in turn; the 32-step CORDIC runs alongside it, and one shared
// multiplier forms the squares and the four loop filter products. The next
// item is accepted only after the result is loaded, so the block takes no new
// item before it is through with the last one.
// s_tready is high only while the sequencer is idle. A finished result waits
// in the output register while the next item is accepted; if the receiver
// still stalls when the next result is ready, the sequencer holds it there.
// Reset clears the loop filter history, the gains and the carrier basis, and
// loads the code basis with the nominal chip rate.
// ----------------------------------------------------------------------------
module gnss_pll_dll_loop_update
    import glu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // early_i, early_q, prompt_i, prompt_q, late_i, late_q
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // phase_error, carrier_command, carrier_freq, delay_error, code_command,
    // code_freq, zero fill
    output logic [255:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    logic [31:0] cprop_reg, cint_reg, kprop_reg, kint_reg;
    logic [47:0] cbasis_reg, kbasis_reg;
    logic [2:0]  cfg_idx;

    glu_state_t state_reg, state_next;

    logic signed [31:0] ei_reg, eq_reg, li_reg, lq_reg;
    logic [63:0]        part_reg, part_next, rad_e_reg, rad_e_next, rad_l_reg, rad_l_next;
    logic [31:0]        mag_e_reg, mag_e_next;
    logic               ge_reg, ge_next;
    logic signed [29:0] perr_reg, perr_next, prev_perr_reg, prev_perr_next;
    logic signed [31:0] derr_reg, derr_next, prev_derr_reg, prev_derr_next;
    logic signed [47:0] prev_ccmd_reg, prev_ccmd_next, prev_kcmd_reg, prev_kcmd_next;
    logic signed [AccW-1:0] acc_c_reg, acc_c_next, acc_k_reg, acc_k_next;
    logic               out_valid_reg, out_valid_next;
    logic [255:0]       out_data_reg, out_data_next;

    logic [31:0]        mul_a, mul_b;
    logic               mul_neg;
    logic [63:0]        prod;
    logic               prod_neg;
    logic signed [TermW-1:0] term;
    logic signed [30:0] dp;
    logic signed [32:0] dd;

    root_ctl_t          root_ctl;
    logic [63:0]        root_operand;
    logic [32:0]        root_div;
    logic               root_done;
    logic [31:0]        root_result;
    logic [32:0]        den;
    logic [31:0]        mag_diff;
    logic [30:0]        quot;

    logic               cordic_start, cordic_valid;
    logic signed [29:0] cordic_phase;
    logic signed [AccW-1:0] cf_sum, kf_sum;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cprop_reg  <= '0;
            cint_reg   <= '0;
            kprop_reg  <= '0;
            kint_reg   <= '0;
            cbasis_reg <= '0;
            kbasis_reg <= CodeRateReset;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (cfg_idx)
                REG_CARRIER_PROP:  cprop_reg  <= pwdata[31:0];
                REG_CARRIER_INT:   cint_reg   <= pwdata[31:0];
                REG_CODE_PROP:     kprop_reg  <= pwdata[31:0];
                REG_CODE_INT:      kint_reg   <= pwdata[31:0];
                REG_CARRIER_BASIS: cbasis_reg <= pwdata[47:0];
                REG_CODE_BASIS:    kbasis_reg <= pwdata[47:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_CARRIER_PROP:  prdata = 64'(cprop_reg);
            REG_CARRIER_INT:   prdata = 64'(cint_reg);
            REG_CODE_PROP:     prdata = 64'(kprop_reg);
            REG_CODE_INT:      prdata = 64'(kint_reg);
            REG_CARRIER_BASIS: prdata = 64'(cbasis_reg);
            REG_CODE_BASIS:    prdata = 64'(kbasis_reg);
            default:           prdata = '0;
        endcase
    end

    glu_mul u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .neg      (mul_neg),
        .prod_reg (prod),
        .neg_reg  (prod_neg)
    );

    glu_root u_root (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (root_ctl),
        .operand (root_operand),
        .divisor (root_div),
        .done    (root_done),
        .result  (root_result)
    );

    glu_cordic u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cordic_start),
        .prompt_i (s_tdata[95:64]),
        .prompt_q (s_tdata[127:96]),
        .valid    (cordic_valid),
        .phase    (cordic_phase)
    );

    assign s_tready     = (state_reg == ST_IDLE);
    assign cordic_start = s_tvalid && s_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (cordic_start)
        begin
            ei_reg <= s_tdata[31:0];
            eq_reg <= s_tdata[63:32];
            li_reg <= s_tdata[159:128];
            lq_reg <= s_tdata[191:160];
        end
        part_reg  <= part_next;
        rad_e_reg <= rad_e_next;
        rad_l_reg <= rad_l_next;
        mag_e_reg <= mag_e_next;
        ge_reg    <= ge_next;
        perr_reg  <= perr_next;
        derr_reg  <= derr_next;
        acc_c_reg <= acc_c_next;
        acc_k_reg <= acc_k_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            prev_perr_reg <= '0;
            prev_derr_reg <= '0;
            prev_ccmd_reg <= '0;
            prev_kcmd_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            prev_perr_reg <= prev_perr_next;
            prev_derr_reg <= prev_derr_next;
            prev_ccmd_reg <= prev_ccmd_next;
            prev_kcmd_reg <= prev_kcmd_next;
        end
    end

    always_comb
    begin
        dp       = 31'(perr_reg) - 31'(prev_perr_reg);
        dd       = 33'(derr_reg) - 33'(prev_derr_reg);
        term     = round_term(prod, prod_neg);
        den      = 33'(mag_e_reg) + 33'(root_result);
        mag_diff = (mag_e_reg >= root_result) ? mag_e_reg - root_result
                                              : root_result - mag_e_reg;
        quot     = root_result[30:0];
        cf_sum   = AccW'(cbasis_reg) + AccW'(prev_ccmd_reg);
        kf_sum   = AccW'(kbasis_reg) - AccW'(prev_kcmd_reg);

        state_next     = state_reg;
        part_next      = part_reg;
        rad_e_next     = rad_e_reg;
        rad_l_next     = rad_l_reg;
        mag_e_next     = mag_e_reg;
        ge_next        = ge_reg;
        perr_next      = perr_reg;
        derr_next      = derr_reg;
        acc_c_next     = acc_c_reg;
        acc_k_next     = acc_k_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        prev_perr_next = prev_perr_reg;
        prev_derr_next = prev_derr_reg;
        prev_ccmd_next = prev_ccmd_reg;
        prev_kcmd_next = prev_kcmd_reg;
        mul_a          = '0;
        mul_b          = '0;
        mul_neg        = 1'b0;
        root_ctl       = '{start: 1'b0, mode: ROOT_SQRT};
        root_operand   = rad_e_reg;
        root_div       = den;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_SQ_EI;
            end
            ST_SQ_EI:
            begin
                mul_a      = abs32(ei_reg);
                mul_b      = abs32(ei_reg);
                state_next = ST_SQ_EQ;
            end
            ST_SQ_EQ:
            begin
                part_next  = prod;
                mul_a      = abs32(eq_reg);
                mul_b      = abs32(eq_reg);
                state_next = ST_SQ_LI;
            end
            ST_SQ_LI:
            begin
                rad_e_next = part_reg + prod;
                mul_a      = abs32(li_reg);
                mul_b      = abs32(li_reg);
                state_next = ST_SQ_LQ;
            end
            ST_SQ_LQ:
            begin
                part_next  = prod;
                mul_a      = abs32(lq_reg);
                mul_b      = abs32(lq_reg);
                state_next = ST_SUM_L;
            end
            ST_SUM_L:
            begin
                rad_l_next     = part_reg + prod;
                root_ctl.start = 1'b1;
                root_operand   = rad_e_reg;
                state_next     = ST_ROOT_E;
            end
            ST_ROOT_E:
            begin
                if (root_done)
                begin
                    mag_e_next     = root_result;
                    root_ctl.start = 1'b1;
                    root_operand   = rad_l_reg;
                    state_next     = ST_ROOT_L;
                end
            end
            ST_ROOT_L:
            begin
                if (root_done)
                begin
                    ge_next = (mag_e_reg >= root_result);
                    if (den == 33'd0)
                    begin
                        derr_next  = '0;
                        state_next = ST_PHASE;
                    end
                    else
                    begin
                        root_ctl     = '{start: 1'b1, mode: ROOT_DIV};
                        root_operand = (64'(mag_diff) << ErrFracBits) + 64'(den >> 1);
                        state_next   = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (root_done)
                begin
                    derr_next  = ge_reg ? 32'(quot) : -32'(quot);
                    state_next = ST_PHASE;
                end
            end
            ST_PHASE:
            begin
                if (cordic_valid)
                begin
                    perr_next  = cordic_phase;
                    state_next = ST_F0;
                end
            end
            ST_F0:
            begin
                mul_a      = 32'(dp[30] ? -dp : dp);
                mul_b      = cprop_reg;
                mul_neg    = dp[30];
                state_next = ST_F1;
            end
            ST_F1:
            begin
                acc_c_next = AccW'(prev_ccmd_reg) + AccW'(term);
                mul_a      = abs32(32'(perr_reg));
                mul_b      = cint_reg;
                mul_neg    = perr_reg[29];
                state_next = ST_F2;
            end
            ST_F2:
            begin
                acc_c_next = acc_c_reg + AccW'(term);
                mul_a      = 32'(dd[32] ? -dd : dd);
                mul_b      = kprop_reg;
                mul_neg    = dd[32];
                state_next = ST_F3;
            end
            ST_F3:
            begin
                acc_k_next = AccW'(prev_kcmd_reg) + AccW'(term);
                mul_a      = abs32(derr_reg);
                mul_b      = kint_reg;
                mul_neg    = derr_reg[31];
                state_next = ST_F4;
            end
            ST_F4:
            begin
                acc_k_next = acc_k_reg + AccW'(term);
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                prev_ccmd_next = clamp48(acc_c_reg);
                prev_kcmd_next = clamp48(acc_k_reg);
                prev_perr_next = perr_reg;
                prev_derr_next = derr_reg;
                state_next     = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b00, clamp_u48(kf_sum), prev_kcmd_reg,
                                      prev_derr_reg, clamp_u48(cf_sum),
                                      prev_ccmd_reg, prev_perr_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/glu_mul.sv
// ----------------------------------------------------------------------------
// glu_mul
// Shared unsigned 32 by 32 multiplier with a registered product and sign.
// ----------------------------------------------------------------------------
module glu_mul
    import glu_pkg::*;
(
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic        neg,
    output logic [63:0] prod_reg,
    output logic        neg_reg
);

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(a) * 64'(b);
        neg_reg  <= neg;
    end

endmodule

FILE: src/glu_root.sv
// ----------------------------------------------------------------------------
// glu_root
// Digit-serial unit for the integer square root and the envelope division.
// ----------------------------------------------------------------------------
module glu_root
    import glu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  root_ctl_t   ctl,
    input  logic [63:0] operand,
    input  logic [32:0] divisor,
    output logic        done,
    output logic [31:0] result
);

    logic [63:0] v_reg, res_reg, one_reg;
    logic [32:0] den_reg;
    root_mode_t  mode_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [63:0] a_op, b_op;
    logic [64:0] diff;
    logic        ge;

    always_comb
    begin
        if (mode_reg == ROOT_SQRT)
        begin
            a_op = v_reg;
            b_op = res_reg + one_reg;
        end
        else
        begin
            a_op = {v_reg[62:0], one_reg[63]};
            b_op = 64'(den_reg);
        end
        diff = {1'b0, a_op} - {1'b0, b_op};
        ge   = !diff[64];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            mode_reg <= ROOT_SQRT;
        end
        else if (ctl.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            mode_reg <= ctl.mode;
            cnt_reg  <= (ctl.mode == ROOT_SQRT) ? 5'd31 : 5'd30;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            res_reg <= '0;
            den_reg <= divisor;
            if (ctl.mode == ROOT_SQRT)
            begin
                v_reg   <= operand;
                one_reg <= 64'd1 << 62;
            end
            else
            begin
                v_reg   <= operand >> 31;
                one_reg <= operand << 33;
            end
        end
        else if (busy_reg)
        begin
            if (mode_reg == ROOT_SQRT)
            begin
                if (ge)
                begin
                    v_reg   <= diff[63:0];
                    res_reg <= (res_reg >> 1) + one_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                one_reg <= one_reg >> 2;
            end
            else
            begin
                v_reg   <= ge ? diff[63:0] : a_op;
                res_reg <= {res_reg[62:0], ge};
                one_reg <= one_reg << 1;
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg[31:0];

endmodule

FILE: src/glu_cordic.sv
// ----------------------------------------------------------------------------
// glu_cordic
// Vectoring CORDIC, one rotation per cycle, for the Costas phase error.
// ----------------------------------------------------------------------------
module glu_cordic
    import glu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] prompt_i,
    input  logic signed [31:0] prompt_q,
    output logic               valid,
    output logic signed [29:0] phase
);

    logic signed [CordicW-1:0] x_reg, y_reg;
    logic signed [AngleW-1:0]  z_reg;
    logic [4:0]                k_reg;
    logic                      busy_reg, valid_reg;
    logic                      zero_reg;
    logic signed [29:0]        zval_reg;
    logic signed [CordicW-1:0] pi_ext, pq_ext, dx, dy;
    logic signed [AngleW-1:0]  ang, rnd;
    logic signed [AngleW-1:0]  quarter_ext;

    always_comb
    begin
        pi_ext      = CordicW'(prompt_i);
        pq_ext      = CordicW'(prompt_q);
        dx          = y_reg >>> k_reg;
        dy          = x_reg >>> k_reg;
        ang         = AngleW'(angle_entry(k_reg));
        rnd         = (z_reg + AngleW'(2)) >>> 2;
        quarter_ext = AngleW'(Quarter);
        if (zero_reg)
            phase = zval_reg;
        else if (rnd > quarter_ext)
            phase = Quarter;
        else if (rnd < -quarter_ext)
            phase = -Quarter;
        else
            phase = rnd[29:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            k_reg     <= '0;
        end
        else if (start)
        begin
            k_reg     <= '0;
            busy_reg  <= (prompt_i != 32'sd0);
            valid_reg <= (prompt_i == 32'sd0);
        end
        else if (busy_reg)
        begin
            k_reg <= k_reg + 5'd1;
            if (k_reg == 5'(CordicSteps - 1))
            begin
                busy_reg  <= 1'b0;
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            zero_reg <= (prompt_i == 32'sd0);
            if (prompt_q > 32'sd0)
                zval_reg <= Quarter;
            else if (prompt_q < 32'sd0)
                zval_reg <= -Quarter;
            else
                zval_reg <= '0;
            x_reg <= (prompt_i < 0 ? -pi_ext : pi_ext) <<< PrescaleShift;
            y_reg <= (prompt_i < 0 ? -pq_ext : pq_ext) <<< PrescaleShift;
            z_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + ang;
            end
            else
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - ang;
            end
        end
    end

    assign valid = valid_reg;

endmodule
